// File: sv/srb_pkg.sv
// Shared types and constants of the segment reassembly buffer.
`default_nettype none

package srb_pkg;

  localparam int MAX_SEGMENTS  = 16;
  localparam int SEGMENT_BYTES = 438;
  localparam int STORE_DEPTH   = MAX_SEGMENTS * SEGMENT_BYTES;
  localparam int ADDR_W        = 13;
  localparam int SEG_W         = 4;
  localparam int LEN_W         = 10;
  localparam int OFF_W         = 9;
  localparam int TYPE_W        = 16;
  localparam int DATA_W        = 8;
  localparam int BYTES_W       = 13;
  localparam int STAT_W        = 2;

  localparam logic [TYPE_W-1:0]  TYPE_INVALID = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = '1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_NUM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd2;
  localparam logic [STAT_W-1:0] ST_SHORT    = 2'd3;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic                    is_read;
    logic                    first;
    logic [STAT_W-1:0]       status;
    logic                    mem_ok;
    logic [ADDR_W-1:0]       addr;
    logic [DATA_W-1:0]       data;
    logic [MAX_SEGMENTS-1:0] seg_bit;
    logic [MAX_SEGMENTS-1:0] arm_mask;
    logic [SEG_W-1:0]        seg_total;
    logic [LEN_W-1:0]        seg_length;
    logic [TYPE_W-1:0]       block_type;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               duplicate;
    logic               block_full;
    logic [BYTES_W-1:0] total_bytes;
    logic [DATA_W-1:0]  read_data;
  } result_t;

endpackage

`default_nettype wire

// File: sv/srb_front.sv
// Front end: checks each incoming word, forms its store address and queues it.
`default_nettype none

module srb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          req_type_i,
  input  logic [srb_pkg::TYPE_W-1:0]    block_type_i,
  input  logic [srb_pkg::SEG_W-1:0]     seg_number_i,
  input  logic [srb_pkg::SEG_W-1:0]     seg_total_i,
  input  logic [srb_pkg::LEN_W-1:0]     seg_length_i,
  input  logic [srb_pkg::OFF_W-1:0]     byte_offset_i,
  input  logic [srb_pkg::DATA_W-1:0]    data_byte_i,
  input  logic [srb_pkg::ADDR_W-1:0]    read_address_i,
  output logic                          mid_valid_o,
  output srb_pkg::item_t                mid_item_o,
  input  logic                          mid_pop_i
);
  import srb_pkg::*;

  localparam int CNT_W = $clog2(MID_DEPTH + 1);
  localparam int PTR_W = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;

  item_t             item;
  logic [31:0]       seg_ext;
  logic [31:0]       tot_ext;
  logic [31:0]       wr_addr;
  logic              wr_ok;
  item_t             mem_q [MID_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push;

  always_comb begin
    seg_ext = 32'(seg_number_i);
    tot_ext = 32'(seg_total_i);
    wr_addr = (seg_ext - 32'd1) * 32'(SEGMENT_BYTES) + 32'(byte_offset_i);
    wr_ok   = (seg_ext != 32'd0) && (seg_ext < 32'(MAX_SEGMENTS))
              && (LEN_W'(byte_offset_i) < seg_length_i)
              && (32'(byte_offset_i) < 32'(SEGMENT_BYTES))
              && (wr_addr < 32'(STORE_DEPTH));

    item = '0;
    item.is_read    = req_type_i;
    item.first      = (byte_offset_i == '0);
    item.data       = data_byte_i;
    item.seg_total  = seg_total_i;
    item.seg_length = seg_length_i;
    item.block_type = block_type_i;

    if (seg_ext >= 32'(MAX_SEGMENTS) || tot_ext >= 32'(MAX_SEGMENTS)
        || seg_ext == 32'd0 || seg_ext > tot_ext) begin
      item.status = ST_BAD_NUM;
    end else if (32'(seg_length_i) > 32'(SEGMENT_BYTES)) begin
      item.status = ST_OVERSIZE;
    end else if (seg_ext < tot_ext && 32'(seg_length_i) != 32'(SEGMENT_BYTES)) begin
      item.status = ST_SHORT;
    end else begin
      item.status = ST_OK;
    end

    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      item.seg_bit[i]  = (32'(i + 1) == seg_ext);
      item.arm_mask[i] = (32'(i) < tot_ext);
    end

    if (req_type_i) begin
      item.addr   = read_address_i;
      item.mem_ok = (32'(read_address_i) < 32'(STORE_DEPTH));
    end else begin
      item.addr   = wr_addr[ADDR_W-1:0];
      item.mem_ok = wr_ok;
    end
  end

  assign full        = (cnt_q == CNT_W'(MID_DEPTH));
  assign do_push     = push && !full;
  assign mid_valid_o = (cnt_q != '0);
  assign mid_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (mid_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !mid_pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!do_push && mid_pop_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// File: sv/srb_back.sv
// Back end: block state update, byte store and result register.
`default_nettype none

module srb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mid_valid_i,
  input  srb_pkg::item_t               mid_item_i,
  output logic                         mid_pop_o,
  input  logic [srb_pkg::OUT_CNT_W-1:0] out_cnt_i,
  output logic                         res_valid_o,
  output srb_pkg::result_t             res_o
);
  import srb_pkg::*;

  logic [DATA_W-1:0] store_q [STORE_DEPTH];

  logic [MAX_SEGMENTS-1:0] pend_q, pend_d;
  logic [SEG_W-1:0]        left_q, left_d;
  logic [BYTES_W-1:0]      bytes_q, bytes_d;
  logic [TYPE_W-1:0]       type_q, type_d;
  logic                    full_q, full_d;
  logic                    saving_q, saving_d;
  logic [STAT_W-1:0]       sstat_q, sstat_d;

  logic                    fire;
  logic                    we;
  logic [STAT_W-1:0]       status;
  logic                    dup;
  logic [BYTES_W:0]        sum;

  logic                    s2_valid_q;
  logic [STAT_W-1:0]       s2_status_q;
  logic                    s2_dup_q;
  logic                    s2_full_q;
  logic [BYTES_W-1:0]      s2_bytes_q;
  logic                    s2_rd_q;
  logic [DATA_W-1:0]       rdata_q;

  assign fire      = mid_valid_i
                     && ((OUT_CNT_W + 1)'(out_cnt_i) + (OUT_CNT_W + 1)'(s2_valid_q)
                         < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign mid_pop_o = fire;

  always_comb begin
    pend_d   = pend_q;
    left_d   = left_q;
    bytes_d  = bytes_q;
    type_d   = type_q;
    full_d   = full_q;
    saving_d = saving_q;
    sstat_d  = sstat_q;
    we       = 1'b0;
    status   = ST_OK;
    dup      = 1'b0;
    sum      = '0;

    if (mid_item_i.is_read) begin
      status = ST_OK;
    end else if (mid_item_i.first) begin
      status   = mid_item_i.status;
      saving_d = 1'b0;
      sstat_d  = mid_item_i.status;
      if (mid_item_i.status == ST_OK) begin
        if (full_d) begin
          full_d  = 1'b0;
          type_d  = TYPE_INVALID;
          pend_d  = '0;
          bytes_d = '0;
        end
        if (bytes_d != '0 && type_d != mid_item_i.block_type) begin
          full_d  = 1'b0;
          type_d  = TYPE_INVALID;
          pend_d  = '0;
          bytes_d = '0;
        end
        if (bytes_d == '0) begin
          type_d = mid_item_i.block_type;
          left_d = mid_item_i.seg_total;
          pend_d = pend_d | mid_item_i.arm_mask;
        end
        if ((pend_d & mid_item_i.seg_bit) != '0) begin
          pend_d  = pend_d & ~mid_item_i.seg_bit;
          sum     = (BYTES_W + 1)'(bytes_d) + (BYTES_W + 1)'(mid_item_i.seg_length);
          bytes_d = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
          if (left_d != '0) begin
            left_d = left_d - SEG_W'(1);
            if (left_d == '0) begin
              full_d = 1'b1;
            end
          end
          saving_d = 1'b1;
          we       = mid_item_i.mem_ok;
        end else begin
          dup = 1'b1;
        end
      end
    end else begin
      status = sstat_q;
      we     = saving_q && mid_item_i.mem_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      left_q     <= '0;
      bytes_q    <= '0;
      type_q     <= TYPE_INVALID;
      full_q     <= 1'b0;
      saving_q   <= 1'b0;
      sstat_q    <= ST_OK;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= fire;
      if (fire) begin
        pend_q   <= pend_d;
        left_q   <= left_d;
        bytes_q  <= bytes_d;
        type_q   <= type_d;
        full_q   <= full_d;
        saving_q <= saving_d;
        sstat_q  <= sstat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s2_status_q <= status;
      s2_dup_q    <= dup;
      s2_full_q   <= full_d;
      s2_bytes_q  <= bytes_d;
      s2_rd_q     <= mid_item_i.is_read && mid_item_i.mem_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && we) begin
      store_q[mid_item_i.addr] <= mid_item_i.data;
    end
    if (fire && mid_item_i.is_read && mid_item_i.mem_ok) begin
      rdata_q <= store_q[mid_item_i.addr];
    end
  end

  always_comb begin
    res_valid_o       = s2_valid_q;
    res_o.status      = s2_status_q;
    res_o.duplicate   = s2_dup_q;
    res_o.block_full  = s2_full_q;
    res_o.total_bytes = s2_bytes_q;
    res_o.read_data   = s2_rd_q ? rdata_q : '0;
  end

endmodule

`default_nettype wire

// File: sv/srb_out_queue.sv
// Result queue that holds finished result words until they are popped.
`default_nettype none

module srb_out_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  input  srb_pkg::result_t              res_i,
  output logic [srb_pkg::OUT_CNT_W-1:0] cnt_o,
  input  logic                          pop,
  output logic                          empty,
  output srb_pkg::result_t              head_o
);
  import srb_pkg::*;

  result_t              mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign empty  = (cnt_q == '0);
  assign do_pop = pop && !empty;
  assign cnt_o  = cnt_q;
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (res_valid_i && !do_pop) begin
      cnt_d = cnt_q + OUT_CNT_W'(1);
    end else if (!res_valid_i && do_pop) begin
      cnt_d = cnt_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (res_valid_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/segment_reassembly_buffer.sv
// Each word passes the front-end queue, the back-end result registers and the result queue.
// Throughput: one word per cycle when the result queue has room, set by the single store port.
// A two-entry queue after the front end and a four-entry result queue absorb stalls.
// Reset is asynchronous and active low; it empties the queues and clears the block state.
// The byte store is not cleared; a byte never written reads as an unknown value.
`default_nettype none

module segment_reassembly_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type_i,
  input  logic [15:0]                block_type_i,
  input  logic [3:0]                 seg_number_i,
  input  logic [3:0]                 seg_total_i,
  input  logic [9:0]                 seg_length_i,
  input  logic [8:0]                 byte_offset_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [12:0]                read_address_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 status_o,
  output logic                       duplicate_o,
  output logic                       block_full_o,
  output logic [12:0]                total_bytes_o,
  output logic [7:0]                 read_data_o
);
  import srb_pkg::*;

  logic                 mid_valid;
  item_t                mid_item;
  logic                 mid_pop;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic                 res_valid;
  result_t              res;
  result_t              head;

  srb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .block_type_i   (block_type_i),
    .seg_number_i   (seg_number_i),
    .seg_total_i    (seg_total_i),
    .seg_length_i   (seg_length_i),
    .byte_offset_i  (byte_offset_i),
    .data_byte_i    (data_byte_i),
    .read_address_i (read_address_i),
    .mid_valid_o    (mid_valid),
    .mid_item_o     (mid_item),
    .mid_pop_i      (mid_pop)
  );

  srb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_item_i  (mid_item),
    .mid_pop_o   (mid_pop),
    .out_cnt_i   (out_cnt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srb_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .cnt_o       (out_cnt),
    .pop         (pop),
    .empty       (empty),
    .head_o      (head)
  );

  assign status_o      = head.status;
  assign duplicate_o   = head.duplicate;
  assign block_full_o  = head.block_full;
  assign total_bytes_o = head.total_bytes;
  assign read_data_o   = head.read_data;

endmodule

`default_nettype wire

// File: tb/segment_reassembly_buffer_tb.sv
// Self-checking testbench of the segment reassembly buffer: directed and random words.
module segment_reassembly_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          ADDR_TOP    = (1 << ADDR_W) - 1;
  localparam int          OFF_TOP     = (1 << OFF_W) - 1;
  localparam int          LEN_TOP     = (1 << LEN_W) - 1;

  typedef struct packed {
    logic              is_read;
    logic [TYPE_W-1:0] btype;
    logic [SEG_W-1:0]  seg;
    logic [SEG_W-1:0]  nseg;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] data;
    logic [ADDR_W-1:0] raddr;
  } seg_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic req_type_i = 1'b0;
  logic [15:0] block_type_i = '0;
  logic [3:0] seg_number_i = '0;
  logic [3:0] seg_total_i = '0;
  logic [9:0] seg_length_i = '0;
  logic [8:0] byte_offset_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [12:0] read_address_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] status_o;
  logic duplicate_o;
  logic block_full_o;
  logic [12:0] total_bytes_o;
  logic [7:0] read_data_o;

  segment_reassembly_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .block_type_i  (block_type_i),
    .seg_number_i  (seg_number_i),
    .seg_total_i   (seg_total_i),
    .seg_length_i  (seg_length_i),
    .byte_offset_i (byte_offset_i),
    .data_byte_i   (data_byte_i),
    .read_address_i(read_address_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .duplicate_o   (duplicate_o),
    .block_full_o  (block_full_o),
    .total_bytes_o (total_bytes_o),
    .read_data_o   (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [DATA_W-1:0]       block_mem [STORE_DEPTH];
  bit                      written [STORE_DEPTH];
  int                      written_addrs[$];
  logic [MAX_SEGMENTS-1:0] pending_segs = '0;
  logic [SEG_W-1:0]        segs_left = '0;
  logic [BYTES_W-1:0]      byte_count = '0;
  logic [TYPE_W-1:0]       cur_type = TYPE_INVALID;
  bit                      blk_full = 1'b0;
  bit                      saving = 1'b0;
  logic [STAT_W-1:0]       seg_stat = ST_OK;

  result_t           replies_due[$];
  int                fail_count = 0;
  int                words_sent = 0;
  int                send_idle_pct = 33;
  int                recv_idle_pct = 55;
  int unsigned       cycle_count = 0;
  logic [TYPE_W-1:0] block_types [3];

  function automatic void drop_block();
    blk_full     = 1'b0;
    cur_type     = TYPE_INVALID;
    pending_segs = '0;
    byte_count   = '0;
  endfunction

  function automatic void store_payload(int seg, int off, int len, logic [DATA_W-1:0] val);
    int addr;
    if (seg == 0 || seg >= MAX_SEGMENTS || off >= len || off >= SEGMENT_BYTES) return;
    addr = (seg - 1) * SEGMENT_BYTES + off;
    if (addr < STORE_DEPTH) begin
      block_mem[addr] = val;
      if (!written[addr]) begin
        written[addr] = 1'b1;
        written_addrs.push_back(addr);
      end
    end
  endfunction

  function automatic result_t reassemble_word(input seg_word_t w);
    result_t                 r;
    logic [MAX_SEGMENTS-1:0] seg_bit;
    logic [MAX_SEGMENTS-1:0] arm;
    int                      sum;
    r = '0;
    if (w.is_read) begin
      if (int'(w.raddr) < STORE_DEPTH) r.read_data = block_mem[w.raddr];
    end else if (w.off == '0) begin
      if (int'(w.seg) >= MAX_SEGMENTS || int'(w.nseg) >= MAX_SEGMENTS || w.seg == '0 ||
          w.seg > w.nseg) begin
        r.status = ST_BAD_NUM;
      end else if (int'(w.len) > SEGMENT_BYTES) begin
        r.status = ST_OVERSIZE;
      end else if (w.seg < w.nseg && int'(w.len) != SEGMENT_BYTES) begin
        r.status = ST_SHORT;
      end
      saving   = 1'b0;
      seg_stat = r.status;
      if (r.status == ST_OK) begin
        seg_bit = MAX_SEGMENTS'(1 << (int'(w.seg) - 1));
        if (blk_full) drop_block();
        if (byte_count != '0 && cur_type != w.btype) drop_block();
        if (byte_count == '0) begin
          cur_type     = w.btype;
          segs_left    = w.nseg;
          arm          = MAX_SEGMENTS'((1 << int'(w.nseg)) - 1);
          pending_segs = pending_segs | arm;
        end
        if ((pending_segs & seg_bit) != '0) begin
          pending_segs = pending_segs & ~seg_bit;
          sum = int'(byte_count) + int'(w.len);
          byte_count = (sum > int'(BYTES_MAX)) ? BYTES_MAX : sum[BYTES_W-1:0];
          if (segs_left != '0) begin
            segs_left = segs_left - SEG_W'(1);
            if (segs_left == '0) blk_full = 1'b1;
          end
          saving = 1'b1;
          store_payload(int'(w.seg), int'(w.off), int'(w.len), w.data);
        end else begin
          r.duplicate = 1'b1;
        end
      end
    end else begin
      r.status = seg_stat;
      if (saving) store_payload(int'(w.seg), int'(w.off), int'(w.len), w.data);
    end
    r.block_full  = blk_full;
    r.total_bytes = byte_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (replies_due.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("duplicate", 16'(want.duplicate), 16'(duplicate_o));
          check_field("block_full", 16'(want.block_full), 16'(block_full_o));
          check_field("total_bytes", 16'(want.total_bytes), 16'(total_bytes_o));
          check_field("read_data", 16'(want.read_data), 16'(read_data_o));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(input seg_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    req_type_i     <= w.is_read;
    block_type_i   <= w.btype;
    seg_number_i   <= w.seg;
    seg_total_i    <= w.nseg;
    seg_length_i   <= w.len;
    byte_offset_i  <= w.off;
    data_byte_i    <= w.data;
    read_address_i <= w.raddr;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    replies_due.push_back(reassemble_word(w));
    words_sent++;
  endtask

  function automatic seg_word_t seg_word(logic [TYPE_W-1:0] btype, int seg, int nseg, int len,
                                         int off, logic [DATA_W-1:0] data);
    seg_word_t w;
    w.is_read = 1'b0;
    w.btype   = btype;
    w.seg     = SEG_W'(seg);
    w.nseg    = SEG_W'(nseg);
    w.len     = LEN_W'(len);
    w.off     = OFF_W'(off);
    w.data    = data;
    w.raddr   = ADDR_W'($urandom_range(ADDR_TOP));
    return w;
  endfunction

  // Reads go only to bytes already written, or past the end of the store.
  function automatic int pick_read_addr();
    if (written_addrs.size() > 0 && $urandom_range(4) != 0)
      return written_addrs[$urandom_range(written_addrs.size() - 1)];
    return $urandom_range(ADDR_TOP, STORE_DEPTH);
  endfunction

  function automatic seg_word_t read_word(int addr);
    seg_word_t w;
    w = seg_word(TYPE_W'($urandom_range(16'hFFFF)), $urandom_range(15), $urandom_range(15),
                 $urandom_range(LEN_TOP), $urandom_range(OFF_TOP),
                 DATA_W'($urandom_range(255)));
    w.is_read = 1'b1;
    w.raddr   = ADDR_W'(addr);
    return w;
  endfunction

  function automatic seg_word_t noise_word();
    if ($urandom_range(1)) return read_word(pick_read_addr());
    return seg_word(TYPE_W'($urandom_range(16'hFFFF)), $urandom_range(15), $urandom_range(15),
                    $urandom_range(LEN_TOP), $urandom_range(1) ? 0 : $urandom_range(OFF_TOP),
                    DATA_W'($urandom_range(255)));
  endfunction

  task automatic send_segment(logic [TYPE_W-1:0] btype, int seg, int nseg, int len);
    int extra;
    int off;
    extra = $urandom_range(4);
    send_word(seg_word(btype, seg, nseg, len, 0, DATA_W'($urandom_range(255))));
    for (int i = 1; i <= extra; i++) begin
      case ($urandom_range(4))
        0: off = $urandom_range(OFF_TOP, 1);
        1: off = (len > 1) ? len - 1 : i;
        default: off = i;
      endcase
      send_word(seg_word(btype, seg, nseg, len, off, DATA_W'($urandom_range(255))));
    end
  endtask

  task automatic run_block();
    int                nseg;
    int                last;
    int                j;
    int                tmp;
    int                len;
    int                order [MAX_SEGMENTS];
    logic [TYPE_W-1:0] btype;
    nseg  = ($urandom_range(3) == 0) ? $urandom_range(MAX_SEGMENTS - 1, 1) : $urandom_range(3, 1);
    btype = block_types[$urandom_range(2)];
    for (int i = 0; i < nseg; i++) order[i] = i + 1;
    for (int i = nseg - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    last = ($urandom_range(4) == 0) ? $urandom_range(nseg, 1) : nseg;
    for (int i = 0; i < last; i++) begin
      len = (order[i] < nseg) ? SEGMENT_BYTES : $urandom_range(SEGMENT_BYTES);
      if ($urandom_range(9) == 0) len = $urandom_range(LEN_TOP);
      send_segment(btype, order[i], nseg, len);
      if ($urandom_range(7) == 0) send_segment(btype, order[i], nseg, len);
      if ($urandom_range(3) == 0) send_word(read_word(pick_read_addr()));
    end
  endtask

  task automatic test_rejections();
    send_word(seg_word(16'h0001, 0, 1, 5, 0, 8'h11));
    send_word(seg_word(16'h0001, 3, 2, 5, 0, 8'h22));
    send_word(seg_word(16'h0001, 3, 2, 5, 1, 8'h33));
    send_word(seg_word(16'h0001, 1, 1, SEGMENT_BYTES + 1, 0, 8'h44));
    send_word(seg_word(16'h0001, 1, 1, LEN_TOP, 0, 8'h55));
    send_word(seg_word(16'h0001, 1, 2, 100, 0, 8'h66));
    send_word(seg_word(16'h0001, 1, 2, 100, 1, 8'h77));
  endtask

  task automatic test_single_block_and_reads();
    send_word(seg_word(16'h0000, 1, 1, 3, 0, 8'h00));
    send_word(seg_word(16'h0000, 1, 1, 3, 1, 8'hFF));
    send_word(seg_word(16'h0000, 1, 1, 3, 2, 8'h5A));
    send_word(read_word(0));
    send_word(read_word(2));
    send_word(read_word(ADDR_TOP));
    send_word(read_word(STORE_DEPTH));
  endtask

  task automatic test_duplicate_and_type_change();
    send_word(seg_word(16'hFFFF, 2, 2, 5, 0, 8'hA5));
    send_word(seg_word(16'hFFFF, 2, 2, 5, 0, 8'h5A));
    send_word(seg_word(16'hFFFF, 2, 2, 5, 1, 8'hC3));
    send_word(seg_word(16'h1234, 2, 2, 7, 0, 8'h3C));
    send_word(seg_word(16'h1234, 1, 2, SEGMENT_BYTES, 0, 8'h81));
    send_word(seg_word(16'h1234, 1, 2, SEGMENT_BYTES, SEGMENT_BYTES - 1, 8'h7E));
    send_word(seg_word(16'h1234, 1, 2, SEGMENT_BYTES, SEGMENT_BYTES, 8'h18));
    send_word(seg_word(16'h1234, 1, 2, SEGMENT_BYTES, OFF_TOP, 8'hE7));
    send_word(read_word(SEGMENT_BYTES - 1));
  endtask

  task automatic test_zero_length();
    send_word(seg_word(16'hABCD, 15, 15, 0, 0, 8'hFF));
    send_word(seg_word(16'hABCD, 14, 15, SEGMENT_BYTES, 0, 8'h99));
  endtask

  task automatic test_random_traffic(int s_idle, int r_idle, int words);
    int goal;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    goal          = words_sent + words;
    foreach (block_types[i]) block_types[i] = TYPE_W'($urandom_range(16'hFFFF));
    while (words_sent < goal) begin
      case ($urandom_range(9))
        7: repeat ($urandom_range(3, 1)) send_word(noise_word());
        8, 9: repeat ($urandom_range(3, 1)) send_word(read_word(pick_read_addr()));
        default: run_block();
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rejections();
    test_single_block_and_reads();
    test_duplicate_and_type_change();
    test_zero_length();
    test_random_traffic(33, 55, 233);
    test_random_traffic(55, 33, 233);
    test_random_traffic(0, 0, 234);
    push <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/srb_pkg.sv
sv/srb_front.sv
sv/srb_back.sv
sv/srb_out_queue.sv
sv/segment_reassembly_buffer.sv
tb/segment_reassembly_buffer_tb.sv
